// ===== hw/rtl/nfra_pkg.sv =====
// Shared types, constants and a helper function for the next-fit register allocator.
// Used by the controller, the datapath and the top level.
package nfra_pkg;

  localparam int IDX_W = 5;
  localparam int NUM_SLOTS = 1 << IDX_W;
  localparam int CNT_W = 5;
  localparam int STATUS_W = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [NUM_SLOTS-1:0] slot_map_t;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  function automatic slot_map_t window_mask(int first, int last, int nregs);
    slot_map_t m;
    m = '0;
    for (int r = 0; r < NUM_SLOTS; r++) begin
      if (r >= first && r <= last && r < nregs) begin
        m[r] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/nfra_req_if.sv =====
// Request channel of the allocator: valid/ready handshake with kind and index.
// Depends on nothing but the language.
interface nfra_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] reg_index;

  modport source (output valid, output kind, output reg_index, input ready);
  modport sink (input valid, input kind, input reg_index, output ready);
endinterface

// ===== hw/rtl/nfra_rsp_if.sv =====
// Result channel of the allocator: valid/ready handshake with status, index and count.
// Depends on nothing but the language.
interface nfra_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] granted_index;
  logic [4:0] free_count;

  modport source (output valid, output status, output granted_index, output free_count,
                  input ready);
  modport sink (input valid, input status, input granted_index, input free_count,
                output ready);
endinterface

// ===== hw/rtl/nfra_ctrl.sv =====
// Controller state machine of the allocator: sequences capture and execution.
// Depends on nfra_pkg for the state and command types.
module nfra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output nfra_pkg::cmd_t cmd
);
  import nfra_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.execute = !out_valid || rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign rsp_valid = out_valid;

endmodule

// ===== hw/rtl/nfra_datapath.sv =====
// Datapath of the allocator: free bitmap, search pointer, free count and result register.
// Depends on nfra_pkg for types, status codes and the window mask function.
module nfra_datapath #(
  parameter int FIRST_ALLOC = 8,
  parameter int LAST_ALLOC  = 25,
  parameter int NUM_REGS    = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  nfra_pkg::cmd_t    cmd,
  input  logic              kind,
  input  nfra_pkg::idx_t    reg_index,
  output nfra_pkg::status_t status,
  output nfra_pkg::idx_t    granted_index,
  output nfra_pkg::cnt_t    free_count
);
  import nfra_pkg::*;

  localparam slot_map_t WIN_MASK = window_mask(FIRST_ALLOC, LAST_ALLOC, NUM_REGS);
  localparam idx_t FIRST_IDX = IDX_W'(FIRST_ALLOC);
  localparam cnt_t RESET_TOTAL = CNT_W'(LAST_ALLOC - FIRST_ALLOC + 1);

  logic      req_kind;
  idx_t      req_idx;
  slot_map_t free_map;
  idx_t      search_start;
  cnt_t      free_total;

  idx_t      start;
  slot_map_t upper;
  slot_map_t pick;
  slot_map_t lowest;
  idx_t      found_idx;
  logic      found;
  logic      idx_in_window;
  logic      idx_is_free;
  status_t   step_status;
  idx_t      step_grant;
  slot_map_t free_map_next;
  idx_t      search_start_next;
  cnt_t      free_total_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_kind <= kind;
      req_idx  <= reg_index;
    end
  end

  always_comb begin
    start     = WIN_MASK[search_start] ? search_start : FIRST_IDX;
    upper     = free_map & ({NUM_SLOTS{1'b1}} << start);
    pick      = (upper != '0) ? upper : free_map;
    lowest    = pick & (~pick + slot_map_t'(1));
    found     = free_map != '0;
    found_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (lowest[i]) begin
        found_idx = found_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    idx_in_window     = WIN_MASK[req_idx];
    idx_is_free       = free_map[req_idx];
    step_status       = ST_OK;
    step_grant        = '0;
    free_map_next     = free_map;
    search_start_next = search_start;
    free_total_next   = free_total;
    if (req_kind == KIND_ALLOC) begin
      if (found) begin
        free_map_next[found_idx] = 1'b0;
        search_start_next        = found_idx;
        free_total_next          = free_total - cnt_t'(1);
        step_grant               = found_idx;
      end else begin
        step_status = ST_NONE_FREE;
      end
    end else begin
      if (!idx_in_window) begin
        step_status = ST_RANGE;
      end else if (idx_is_free) begin
        step_status = ST_NOT_ALLOC;
      end else begin
        free_map_next[req_idx] = 1'b1;
        free_total_next        = free_total + cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map     <= WIN_MASK;
      search_start <= FIRST_IDX;
      free_total   <= RESET_TOTAL;
    end else if (cmd.execute) begin
      free_map     <= free_map_next;
      search_start <= search_start_next;
      free_total   <= free_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status        <= step_status;
      granted_index <= step_grant;
      free_count    <= free_total_next;
    end
  end

endmodule

// ===== hw/rtl/next_fit_register_allocator.sv =====
// Next-fit register allocator for a window of register indices.
// Requests arrive on the req channel (kind, reg_index); each gives one transfer on the
// rsp channel carrying status, granted_index and free_count. Both channels transfer
// when valid and ready are high at a rising edge of clk.
// An allocate request searches the free bitmap from the next-fit pointer with
// wrap-around and grants the first free index; a free request returns an index
// after checking that it lies in the window and is currently allocated.
// Each request passes through the controller states S_IDLE, which captures it, and
// S_EXEC, in which the datapath runs the rotating priority search over the bitmap, updates its state
// and loads the result register. The result is valid the cycle after that, and
// a new request is taken only once the controller has returned to S_IDLE.
// While a result waits for the receiver, the next request is still captured,
// but its execution holds until the result register has been taken.
// A synchronous reset on rst marks every window index free, sets the pointer to
// the first allocatable index and the free count to the window size; no clearing
// pass is needed.
// Depends on nfra_pkg, nfra_req_if, nfra_rsp_if, nfra_ctrl and nfra_datapath.
module next_fit_register_allocator #(
  parameter int FIRST_ALLOC = 8,
  parameter int LAST_ALLOC  = 25,
  parameter int NUM_REGS    = 32
) (
  input logic clk,
  input logic rst,
  nfra_req_if.sink   req,
  nfra_rsp_if.source rsp
);
  import nfra_pkg::*;

  cmd_t    cmd;
  status_t dp_status;
  idx_t    dp_grant;
  cnt_t    dp_count;

  nfra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  nfra_datapath #(
    .FIRST_ALLOC (FIRST_ALLOC),
    .LAST_ALLOC  (LAST_ALLOC),
    .NUM_REGS    (NUM_REGS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (req.kind),
    .reg_index     (req.reg_index),
    .status        (dp_status),
    .granted_index (dp_grant),
    .free_count    (dp_count)
  );

  assign rsp.status        = dp_status;
  assign rsp.granted_index = dp_grant;
  assign rsp.free_count    = dp_count;

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> rsp.valid)
    else $error("Executed request did not produce a result.");

  a_no_grant_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.granted_index == '0)
    else $error("Index granted on a failed request.");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_NONE_FREE |-> rsp.free_count == '0)
    else $error("Exhaustion reported with a nonzero free count.");

  a_capture_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> !req.ready && !cmd.capture)
    else $error("Request captured while the previous one was still executing.");

endmodule
